// ===== rtl/inverse_affine_matrix_setup_core_assert.svh =====
// assertion macros for the inverse affine matrix setup core
// expects clk and rst in the scope where the macros are used
`ifndef INVERSE_AFFINE_MATRIX_SETUP_CORE_ASSERT_SVH
`define INVERSE_AFFINE_MATRIX_SETUP_CORE_ASSERT_SVH

// same-cycle implication
`define IAMS_ASSERT_COMB(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IAMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/iams_pkg.sv =====
// shared widths, constants, stage types and saturation helpers
// used by every module of the inverse affine matrix setup core
`timescale 1ns / 1ps

package iams_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANG_W = 20;
  localparam int XY_W = 20;
  localparam int CS_W = 18;
  localparam int P_W = 34;
  localparam int Q_W = 48;
  localparam int PX_W = 51;
  localparam int NUM_W = 64;
  localparam int DIV_W = 56;
  localparam int DEN_W = 16;
  localparam int LANES = 6;
  localparam int LANE_ROW = 3;
  localparam int SQ_W = DIV_W + 1;
  localparam int OFS_W = DIV_W + 2;

  localparam int LANE_P = 0;
  localparam int LANE_Q = 1;
  localparam int LANE_NX = 2;
  localparam int LANE_R = 3;
  localparam int LANE_T = 4;
  localparam int LANE_NY = 5;

  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [16:0] PI_Q13 = 17'sd25736;
  localparam logic signed [XY_W-1:0] GAIN_INV_Q16 = 20'sd39797;
  localparam logic signed [CS_W-1:0] ONE_Q16 = 18'sd65536;

  localparam logic signed [ANG_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2
  };

  typedef struct packed {
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic signed [15:0] shear_x;
    logic signed [15:0] shear_y;
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
  } item_t;

  typedef struct packed {
    logic [DEN_W-1:0]   den_x;
    logic [DEN_W-1:0]   den_y;
    logic [LANES-1:0]   neg;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
    logic [1:0]         zero;
  } div_side_t;

  typedef struct packed {
    logic [31:0] c00;
    logic [31:0] c01;
    logic [47:0] c02;
    logic [31:0] c10;
    logic [31:0] c11;
    logic [47:0] c12;
    logic [1:0]  zero;
  } coef_t;

  function automatic logic [31:0] sat32(input logic signed [OFS_W-1:0] v);
    if ((&v[OFS_W-1:31]) || !(|v[OFS_W-1:31])) return v[31:0];
    else if (v[OFS_W-1]) return 32'h8000_0000;
    else return 32'h7FFF_FFFF;
  endfunction

  function automatic logic [47:0] sat48(input logic signed [OFS_W-1:0] v);
    if ((&v[OFS_W-1:47]) || !(|v[OFS_W-1:47])) return v[47:0];
    else if (v[OFS_W-1]) return 48'h8000_0000_0000;
    else return 48'h7FFF_FFFF_FFFF;
  endfunction

endpackage

// ===== rtl/iams_cordic.sv =====
// pipelined rotation-mode cordic: range reduction, one stage per iteration, clamp
// depends on iams_pkg
`timescale 1ns / 1ps

module iams_cordic
  import iams_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic signed [15:0]     angle,
  input  item_t                  in_item,
  output logic                   out_vld,
  output logic signed [CS_W-1:0] sin_q16,
  output logic signed [CS_W-1:0] cos_q16,
  output item_t                  out_item
);

  logic                   vld  [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] x    [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] y    [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] z   [CORDIC_STEPS+1];
  logic                   flip [CORDIC_STEPS+1];
  item_t                  item [CORDIC_STEPS+1];

  logic signed [16:0] ang_ext;
  logic signed [16:0] ang_red;
  logic               flip_in;
  logic signed [XY_W-1:0] fx;
  logic signed [XY_W-1:0] fy;
  logic               cl_vld;

  function automatic logic signed [CS_W-1:0] clamp_unit(input logic signed [XY_W-1:0] v);
    if (v > XY_W'(ONE_Q16)) return ONE_Q16;
    else if (v < -XY_W'(ONE_Q16)) return -ONE_Q16;
    else return CS_W'(v);
  endfunction

  // fold into [-pi/2, pi/2], negate the result afterwards
  always_comb begin
    ang_ext = 17'(angle);
    ang_red = ang_ext;
    flip_in = 1'b0;
    if (ang_ext > HALF_PI_Q13) begin
      ang_red = ang_ext - PI_Q13;
      flip_in = 1'b1;
    end else if (ang_ext < -HALF_PI_Q13) begin
      ang_red = ang_ext + PI_Q13;
      flip_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) vld[k] <= 1'b0;
      cl_vld <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      for (int k = 0; k < CORDIC_STEPS; k++) vld[k+1] <= vld[k];
      cl_vld <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= GAIN_INV_Q16;
      y[0]    <= '0;
      z[0]    <= ANG_W'(ang_red) <<< 3;
      flip[0] <= flip_in;
      item[0] <= in_item;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        if (!z[k][ANG_W-1]) begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - ATAN_Q16[k];
        end else begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + ATAN_Q16[k];
        end
        flip[k+1] <= flip[k];
        item[k+1] <= item[k];
      end
      cos_q16  <= clamp_unit(fx);
      sin_q16  <= clamp_unit(fy);
      out_item <= item[CORDIC_STEPS];
    end
  end

  assign fx = flip[CORDIC_STEPS] ? -x[CORDIC_STEPS] : x[CORDIC_STEPS];
  assign fy = flip[CORDIC_STEPS] ? -y[CORDIC_STEPS] : y[CORDIC_STEPS];
  assign out_vld = cl_vld;

endmodule

// ===== rtl/iams_terms.sv =====
// four-stage product pipeline: row terms, offset numerators, magnitudes for the divider
// depends on iams_pkg
`timescale 1ns / 1ps

module iams_terms
  import iams_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic signed [CS_W-1:0]       sin_q16,
  input  logic signed [CS_W-1:0]       cos_q16,
  input  item_t                        in_item,
  output logic                         out_vld,
  output logic [LANES-1:0][DIV_W-1:0]  num,
  output div_side_t                    out_side
);

  logic [3:0] vld;

  logic signed [P_W-1:0]  cs_sh, sn_sh, p_next, r_next;
  logic signed [16:0]     sumx_next, sumy_next;
  logic signed [P_W-1:0]  p1, r1;
  logic signed [CS_W-1:0] s1, c1;
  logic signed [16:0]     sumx1, sumy1;
  item_t                  item1;

  logic signed [Q_W-1:0]  q_next, t_next;
  logic signed [PX_W-1:0] pxp_next, rxp_next;
  logic signed [P_W-1:0]  p2, r2;
  logic signed [Q_W-1:0]  q2, t2;
  logic signed [PX_W-1:0] pxp2, rxp2;
  logic signed [16:0]     sumy2;
  item_t                  item2;

  logic signed [NUM_W-1:0] nx_next, ny_next;
  logic signed [P_W-1:0]   p3, r3;
  logic signed [Q_W-1:0]   q3, t3;
  logic signed [NUM_W-1:0] nx3, ny3;
  item_t                   item3;

  logic [P_W-1:0]   pa, ra;
  logic [Q_W-1:0]   qa, ta;
  logic [NUM_W-1:0] nxa, nya;

  always_comb begin
    cs_sh     = cos_q16 * $signed(in_item.shear_y);
    sn_sh     = sin_q16 * $signed(in_item.shear_y);
    p_next    = (P_W'(cos_q16) <<< 8) - sn_sh;
    r_next    = -(cs_sh + (P_W'(sin_q16) <<< 8));
    sumx_next = 17'($signed(in_item.shift_x)) + 17'($signed(in_item.pivot_x));
    sumy_next = 17'($signed(in_item.shift_y)) + 17'($signed(in_item.pivot_y));
  end

  always_comb begin
    q_next   = (Q_W'(s1) <<< 16) - $signed(item1.shear_x) * p1;
    t_next   = (Q_W'(c1) <<< 16) - $signed(item1.shear_x) * r1;
    pxp_next = p1 * sumx1;
    rxp_next = r1 * sumx1;
  end

  always_comb begin
    nx_next = (NUM_W'(pxp2) <<< 8) + q2 * sumy2;
    ny_next = (NUM_W'(rxp2) <<< 8) + t2 * sumy2;
  end

  // magnitudes; dividing by scale*256 is the same as dropping 8 bits first
  always_comb begin
    pa  = $unsigned(p3[P_W-1] ? -p3 : p3);
    ra  = $unsigned(r3[P_W-1] ? -r3 : r3);
    qa  = $unsigned(q3[Q_W-1] ? -q3 : q3);
    ta  = $unsigned(t3[Q_W-1] ? -t3 : t3);
    nxa = $unsigned(nx3[NUM_W-1] ? -nx3 : nx3);
    nya = $unsigned(ny3[NUM_W-1] ? -ny3 : ny3);
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[2:0], in_vld};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= p_next;
      r1    <= r_next;
      s1    <= sin_q16;
      c1    <= cos_q16;
      sumx1 <= sumx_next;
      sumy1 <= sumy_next;
      item1 <= in_item;

      p2    <= p1;
      r2    <= r1;
      q2    <= q_next;
      t2    <= t_next;
      pxp2  <= pxp_next;
      rxp2  <= rxp_next;
      sumy2 <= sumy1;
      item2 <= item1;

      p3    <= p2;
      r3    <= r2;
      q3    <= q2;
      t3    <= t2;
      nx3   <= nx_next;
      ny3   <= ny_next;
      item3 <= item2;

      num[LANE_P]  <= DIV_W'(pa);
      num[LANE_Q]  <= DIV_W'(qa >> 8);
      num[LANE_NX] <= DIV_W'(nxa >> 8);
      num[LANE_R]  <= DIV_W'(ra);
      num[LANE_T]  <= DIV_W'(ta >> 8);
      num[LANE_NY] <= DIV_W'(nya >> 8);
      out_side.den_x          <= item3.scale_x;
      out_side.den_y          <= item3.scale_y;
      out_side.neg[LANE_P]    <= p3[P_W-1];
      out_side.neg[LANE_Q]    <= q3[Q_W-1];
      out_side.neg[LANE_NX]   <= nx3[NUM_W-1];
      out_side.neg[LANE_R]    <= r3[P_W-1];
      out_side.neg[LANE_T]    <= t3[Q_W-1];
      out_side.neg[LANE_NY]   <= ny3[NUM_W-1];
      out_side.pivot_x        <= item3.pivot_x;
      out_side.pivot_y        <= item3.pivot_y;
      out_side.zero           <= {item3.scale_y == '0, item3.scale_x == '0};
    end
  end

  assign out_vld = vld[3];

endmodule

// ===== rtl/iams_div.sv =====
// six-lane pipelined restoring divider, one quotient bit per lane per stage
// depends on iams_pkg; lanes of row one divide by den_x, row two by den_y
`timescale 1ns / 1ps

module iams_div
  import iams_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [LANES-1:0][DIV_W-1:0] num,
  input  div_side_t                   in_side,
  output logic                        out_vld,
  output logic [LANES-1:0][DIV_W-1:0] quo,
  output div_side_t                   out_side
);

  logic                        vld  [DIV_W];
  logic [LANES-1:0][DIV_W-1:0] w    [DIV_W];
  logic [LANES-1:0][DEN_W-1:0] rem  [DIV_W];
  div_side_t                   side [DIV_W];
  logic [LANES-1:0][DEN_W:0]   st   [DIV_W];

  // returns {quotient bit, new remainder}
  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] r, input logic b,
                                              input logic [DEN_W-1:0] d);
    logic [DEN_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) return {1'b1, DEN_W'(t - {1'b0, d})};
    else return {1'b0, t[DEN_W-1:0]};
  endfunction

  function automatic logic [DEN_W-1:0] lane_den(input div_side_t sd, input int l);
    return (l < LANE_ROW) ? sd.den_x : sd.den_y;
  endfunction

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      st[0][l] = div_step('0, num[l][DIV_W-1], lane_den(in_side, l));
    end
    for (int k = 1; k < DIV_W; k++) begin
      for (int l = 0; l < LANES; l++) begin
        st[k][l] = div_step(rem[k-1][l], w[k-1][l][DIV_W-1], lane_den(side[k-1], l));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_W; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      for (int k = 1; k < DIV_W; k++) vld[k] <= vld[k-1];
    end
  end

  // numerator bits shift out the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= st[0][l][DEN_W-1:0];
        w[0][l]   <= {num[l][DIV_W-2:0], st[0][l][DEN_W]};
      end
      side[0] <= in_side;
      for (int k = 1; k < DIV_W; k++) begin
        for (int l = 0; l < LANES; l++) begin
          rem[k][l] <= st[k][l][DEN_W-1:0];
          w[k][l]   <= {w[k-1][l][DIV_W-2:0], st[k][l][DEN_W]};
        end
        side[k] <= side[k-1];
      end
    end
  end

  assign out_vld  = vld[DIV_W-1];
  assign quo      = w[DIV_W-1];
  assign out_side = side[DIV_W-1];

endmodule

// ===== rtl/inverse_affine_matrix_setup_core.sv =====
// inverse affine matrix setup core, top level
// depends on iams_pkg, iams_cordic, iams_terms, iams_div and the assertion header
//
// usage:
//   param channel: param_valid/param_stall with angle, scale, shear, shift and pivot
//   fields; a transfer happens on a clock edge with param_valid high and param_stall low.
//   coef channel: coef_valid/coef_stall with the six matrix coefficients and the
//   zero_scale flags; a transfer happens on an edge with coef_valid high and coef_stall low.
//   pipeline: the path from a param transfer to coef_valid is 81 registers: an
//   18-stage cordic, 4 product stages, a 56-stage divider (one quotient bit per stage),
//   2 sign and saturation stages and the output register.
//   throughput: one item per cycle while the pipeline is not held; every stage is pipelined, items are independent.
//   stall: the output register is backed by a one-entry skid buffer. when the receiver
//   stalls, the pipeline keeps moving until the skid buffer fills; param_stall is then
//   raised (it is the registered skid-full flag) and the whole pipeline holds.
//   reset: synchronous; clears every valid bit, including the output and skid-buffer flags. no
//   per-item state survives between items.
`timescale 1ns / 1ps

`include "inverse_affine_matrix_setup_core_assert.svh"

module inverse_affine_matrix_setup_core
  import iams_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               param_valid,
  output logic               param_stall,
  input  logic signed [15:0] angle,
  input  logic [15:0]        scale_x,
  input  logic [15:0]        scale_y,
  input  logic signed [15:0] shear_x,
  input  logic signed [15:0] shear_y,
  input  logic signed [15:0] shift_x,
  input  logic signed [15:0] shift_y,
  input  logic signed [15:0] pivot_x,
  input  logic signed [15:0] pivot_y,
  output logic               coef_valid,
  input  logic               coef_stall,
  output logic signed [31:0] coef_00,
  output logic signed [31:0] coef_01,
  output logic signed [47:0] coef_02,
  output logic signed [31:0] coef_10,
  output logic signed [31:0] coef_11,
  output logic signed [47:0] coef_12,
  output logic [1:0]         zero_scale
);

  logic en;
  item_t in_item;

  logic                   cd_vld;
  logic signed [CS_W-1:0] cd_sin, cd_cos;
  item_t                  cd_item;

  logic                        tm_vld;
  logic [LANES-1:0][DIV_W-1:0] tm_num;
  div_side_t                   tm_side;

  logic                        dv_vld;
  logic [LANES-1:0][DIV_W-1:0] dv_quo;
  div_side_t                   dv_side;

  logic                  sg_vld;
  logic signed [SQ_W-1:0] sq [LANES];
  div_side_t             sg_side;

  logic signed [OFS_W-1:0] ofs_x, ofs_y;
  coef_t fin_next;
  logic  fin_vld;
  coef_t fin;

  logic  out_vld;
  coef_t out_r;
  logic  skid_vld;
  coef_t skid_r;
  logic  take;
  logic  push;

  assign en          = !skid_vld;
  assign param_stall = skid_vld;

  assign in_item.scale_x = scale_x;
  assign in_item.scale_y = scale_y;
  assign in_item.shear_x = shear_x;
  assign in_item.shear_y = shear_y;
  assign in_item.shift_x = shift_x;
  assign in_item.shift_y = shift_y;
  assign in_item.pivot_x = pivot_x;
  assign in_item.pivot_y = pivot_y;

  iams_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (param_valid),
    .angle    (angle),
    .in_item  (in_item),
    .out_vld  (cd_vld),
    .sin_q16  (cd_sin),
    .cos_q16  (cd_cos),
    .out_item (cd_item)
  );

  iams_terms u_terms (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (cd_vld),
    .sin_q16  (cd_sin),
    .cos_q16  (cd_cos),
    .in_item  (cd_item),
    .out_vld  (tm_vld),
    .num      (tm_num),
    .out_side (tm_side)
  );

  iams_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (tm_vld),
    .num      (tm_num),
    .in_side  (tm_side),
    .out_vld  (dv_vld),
    .quo      (dv_quo),
    .out_side (dv_side)
  );

  // restore signs of the truncated quotients
  always_ff @(posedge clk) begin
    if (rst) sg_vld <= 1'b0;
    else if (en) sg_vld <= dv_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        sq[l] <= dv_side.neg[l] ? -$signed({1'b0, dv_quo[l]}) : $signed({1'b0, dv_quo[l]});
      end
      sg_side <= dv_side;
    end
  end

  always_comb begin
    ofs_x = (OFS_W'($signed(sg_side.pivot_x)) <<< 16) - OFS_W'(sq[LANE_NX]);
    ofs_y = (OFS_W'($signed(sg_side.pivot_y)) <<< 16) - OFS_W'(sq[LANE_NY]);
    fin_next.zero = sg_side.zero;
    fin_next.c00  = sg_side.zero[0] ? '0 : sat32(OFS_W'(sq[LANE_P]));
    fin_next.c01  = sg_side.zero[0] ? '0 : sat32(OFS_W'(sq[LANE_Q]));
    fin_next.c02  = sg_side.zero[0] ? '0 : sat48(ofs_x);
    fin_next.c10  = sg_side.zero[1] ? '0 : sat32(OFS_W'(sq[LANE_R]));
    fin_next.c11  = sg_side.zero[1] ? '0 : sat32(OFS_W'(sq[LANE_T]));
    fin_next.c12  = sg_side.zero[1] ? '0 : sat48(ofs_y);
  end

  always_ff @(posedge clk) begin
    if (rst) fin_vld <= 1'b0;
    else if (en) fin_vld <= sg_vld;
  end

  always_ff @(posedge clk) begin
    if (en) fin <= fin_next;
  end

  // output register with a one-entry skid buffer
  assign take = out_vld && !coef_stall;
  assign push = en && fin_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (take) begin
        out_vld  <= 1'b1;
        skid_vld <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld || take) out_vld <= 1'b1;
      else skid_vld <= 1'b1;
    end else if (take) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (take) out_r <= skid_r;
    end else if (push) begin
      if (!out_vld || take) out_r <= fin;
      else skid_r <= fin;
    end
  end

  assign coef_valid = out_vld;
  assign coef_00    = $signed(out_r.c00);
  assign coef_01    = $signed(out_r.c01);
  assign coef_02    = $signed(out_r.c02);
  assign coef_10    = $signed(out_r.c10);
  assign coef_11    = $signed(out_r.c11);
  assign coef_12    = $signed(out_r.c12);
  assign zero_scale = out_r.zero;

  `IAMS_ASSERT_COMB(a_skid_has_out, skid_vld, coef_valid, "skid full while output empty")
  `IAMS_ASSERT_NEXT(a_skid_fill, coef_valid && coef_stall && fin_vld && !skid_vld,
                    skid_vld, "stalled result not caught by skid buffer")
  `IAMS_ASSERT_NEXT(a_skid_drain, skid_vld && !coef_stall,
                    coef_valid && !skid_vld, "skid buffer did not drain")
  `IAMS_ASSERT_COMB(a_zero_row, coef_valid && zero_scale[0],
                    coef_00 == 32'sd0 && coef_01 == 32'sd0 && coef_02 == 48'sd0,
                    "zero x scale row not cleared")

endmodule
